// File: rtl/rppa_pkg.sv
// Shared types, constants and the arctangent table for the rectangle
// perimeter point unit. Used by rppa_cordic, rppa_div and the top level.
package rppa_pkg;

  localparam int COORD_BITS    = 12;
  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 8;

  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;                          // cordic datapath
  localparam int UNIT_W       = 31;                          // magnitudes up to 2^30
  localparam int PROD_W       = COORD_BITS + UNIT_W;
  localparam int NUM_W        = PROD_W + FRACTION_BITS;
  localparam int Q_W          = COORD_BITS + FRACTION_BITS + 2;
  localparam int OUT_W        = 20;

  localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30   = 33'sd1073741824;

  localparam logic [1:0] HIT_RIGHT  = 2'd0;
  localparam logic [1:0] HIT_TOP    = 2'd1;
  localparam logic [1:0] HIT_LEFT   = 2'd2;
  localparam logic [1:0] HIT_BOTTOM = 2'd3;

  typedef struct packed {
    logic        [11:0] rect_width;
    logic        [11:0] rect_height;
    logic signed [15:0] angle;
  } in_word_t;

  typedef struct packed {
    logic [19:0] edge_x;
    logic [19:0] edge_y;
    logic [1:0]  edge_hit;
  } out_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [1:0]            quad;
  } cord_side_t;

  typedef struct packed {
    logic [1:0]            hit;
    logic [OUT_W-1:0]      fix;
    logic [COORD_BITS-1:0] size;
    logic                  toward;
    logic                  vert;
    logic                  den_zero;
    logic                  sat;
  } div_side_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// File: rtl/rppa_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Depends on rppa_pkg for widths, start value and the arctangent table.
module rppa_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [rppa_pkg::CW-1:0] in_z,
  input  logic                          in_zero,
  input  rppa_pkg::cord_side_t          in_side,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rppa_pkg::CW-1:0] out_x,
  output logic signed [rppa_pkg::CW-1:0] out_y,
  output logic                          out_zero,
  output rppa_pkg::cord_side_t          out_side
);
  localparam int N = rppa_pkg::CORDIC_STEPS;

  logic                          v_r    [N];
  logic signed [rppa_pkg::CW-1:0] x_r    [N];
  logic signed [rppa_pkg::CW-1:0] y_r    [N];
  logic signed [rppa_pkg::CW-1:0] z_r    [N];
  logic                          zero_r [N];
  rppa_pkg::cord_side_t          side_r [N];
  logic [N-1:0]                  hold;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          pv, pzero;
    logic signed [rppa_pkg::CW-1:0] px, py, pz, x_nxt, y_nxt, z_nxt;
    rppa_pkg::cord_side_t          pside;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign px = rppa_pkg::CORDIC_X0;
      assign py = '0;
      assign pz = in_z;
      assign pzero = in_zero;
      assign pside = in_side;
    end else begin : g_next
      assign pv = v_r[k-1];
      assign px = x_r[k-1];
      assign py = y_r[k-1];
      assign pz = z_r[k-1];
      assign pzero = zero_r[k-1];
      assign pside = side_r[k-1];
    end

    if (k == N-1) begin : g_last_hold
      assign hold[k] = v_r[k] && out_stall;
    end else begin : g_mid_hold
      assign hold[k] = v_r[k] && hold[k+1];
    end

    always_comb begin
      if (!pz[rppa_pkg::CW-1]) begin
        x_nxt = px - (py >>> k);
        y_nxt = py + (px >>> k);
        z_nxt = pz - rppa_pkg::atan_step(k);
      end else begin
        x_nxt = px + (py >>> k);
        y_nxt = py - (px >>> k);
        z_nxt = pz + rppa_pkg::atan_step(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (!hold[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (!hold[k]) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        zero_r[k] <= pzero;
        side_r[k] <= pside;
      end
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = v_r[N-1];
  assign out_x     = x_r[N-1];
  assign out_y     = y_r[N-1];
  assign out_zero  = zero_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: rtl/rppa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rppa_pkg for widths and the side-band struct.
module rppa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rppa_pkg::UNIT_W-1:0]   in_rem,
  input  logic [rppa_pkg::Q_W-1:0]      in_low,
  input  logic [rppa_pkg::UNIT_W-1:0]   in_den,
  input  rppa_pkg::div_side_t           in_side,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rppa_pkg::Q_W-1:0]      out_quo,
  output rppa_pkg::div_side_t           out_side
);
  localparam int N  = rppa_pkg::Q_W;
  localparam int DW = rppa_pkg::UNIT_W;

  logic                v_r    [N];
  logic [DW-1:0]       rem_r  [N];
  logic [N-1:0]        lq_r   [N];
  logic [DW-1:0]       den_r  [N];
  rppa_pkg::div_side_t side_r [N];
  logic [N-1:0]        hold;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                pv, ge;
    logic [DW-1:0]       prem, pden, rem_nxt;
    logic [N-1:0]        plq, lq_nxt;
    logic [DW:0]         t;
    rppa_pkg::div_side_t pside;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign prem = in_rem;
      assign plq = in_low;
      assign pden = in_den;
      assign pside = in_side;
    end else begin : g_next
      assign pv = v_r[k-1];
      assign prem = rem_r[k-1];
      assign plq = lq_r[k-1];
      assign pden = den_r[k-1];
      assign pside = side_r[k-1];
    end

    if (k == N-1) begin : g_last_hold
      assign hold[k] = v_r[k] && out_stall;
    end else begin : g_mid_hold
      assign hold[k] = v_r[k] && hold[k+1];
    end

    // shift in the next dividend bit, the quotient bit fills the low end
    always_comb begin
      t       = {prem, plq[N-1]};
      ge      = (t >= {1'b0, pden});
      rem_nxt = ge ? DW'(t - {1'b0, pden}) : DW'(t);
      lq_nxt  = {plq[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (!hold[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (!hold[k]) begin
        rem_r[k]  <= rem_nxt;
        lq_r[k]   <= lq_nxt;
        den_r[k]  <= pden;
        side_r[k] <= pside;
      end
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = v_r[N-1];
  assign out_quo   = lq_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: rtl/rect_perimeter_point_by_angle_unit.sv
// Top level: ray-from-centre border point of a rectangle by binary angle.
// Depends on rppa_pkg, rppa_cordic and rppa_div.
//
//   channel | ports                         | word
//   input   | in_valid, in_stall, in_word   | rppa_pkg::in_word_t
//   result  | out_valid, out_stall, out_word| rppa_pkg::out_word_t
//
// One word enters per cycle while in_stall is low; the path is the input register,
// 30 CORDIC stages, 5 geometry stages, 22 divider stages and the output register.
// Synchronous active-low reset empties every stage; no clearing pass.
// A stall on the result side holds only the stages that are full; bubbles
// ahead of it keep closing, so input is taken while a result waits and a bubble remains.
module rect_perimeter_point_by_angle_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rppa_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rppa_pkg::out_word_t out_word
);
  localparam int CB = rppa_pkg::COORD_BITS;
  localparam int AB = rppa_pkg::ANGLE_BITS;
  localparam int FB = rppa_pkg::FRACTION_BITS;
  localparam int CW = rppa_pkg::CW;
  localparam int UW = rppa_pkg::UNIT_W;
  localparam int PW = rppa_pkg::PROD_W;
  localparam int NW = rppa_pkg::NUM_W;
  localparam int QW = rppa_pkg::Q_W;
  localparam int OW = rppa_pkg::OUT_W;

  logic hold0, hold1, hold2, hold3, hold4, hold5, hold6;

  // ---------------- input register
  logic                 v0_r, zero0_r;
  logic signed [CW-1:0] z0_r;
  rppa_pkg::cord_side_t side0_r;
  logic [AB-1:0]        phase;
  logic                 cord_in_stall;

  assign phase = AB'(in_word.angle);
  assign hold0 = v0_r && cord_in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (!hold0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold0) begin
      z0_r         <= CW'({phase[AB-3:0], {(32-AB){1'b0}}});
      zero0_r      <= (phase[AB-3:0] == '0);
      side0_r.w    <= CB'(in_word.rect_width);
      side0_r.h    <= CB'(in_word.rect_height);
      side0_r.quad <= phase[AB-1:AB-2];
    end
  end

  // ---------------- CORDIC
  logic                 cv, czero;
  logic signed [CW-1:0] cx, cy;
  rppa_pkg::cord_side_t cside;

  rppa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_stall  (cord_in_stall),
    .in_z      (z0_r),
    .in_zero   (zero0_r),
    .in_side   (side0_r),
    .out_valid (cv),
    .out_stall (hold1),
    .out_x     (cx),
    .out_y     (cy),
    .out_zero  (czero),
    .out_side  (cside)
  );

  // ---------------- stage 1: clamp, apply quadrant
  logic          v1_r, cp1_r, cn1_r, sp1_r, sn1_r;
  logic [UW-1:0] ac1_r, as1_r;
  logic [CB-1:0] w1_r, h1_r;
  logic [UW-1:0] qc, qs, ac_nxt, as_nxt;
  logic          cp_nxt, cn_nxt, sp_nxt, sn_nxt;

  assign hold1 = v1_r && hold2;

  always_comb begin
    if (czero) begin
      qc = UW'(rppa_pkg::ONE_Q30);
      qs = '0;
    end else begin
      qc = cx[CW-1] ? '0 : (cx > rppa_pkg::ONE_Q30) ? UW'(rppa_pkg::ONE_Q30) : UW'(cx);
      qs = cy[CW-1] ? '0 : (cy > rppa_pkg::ONE_Q30) ? UW'(rppa_pkg::ONE_Q30) : UW'(cy);
    end
    cp_nxt = 1'b0; cn_nxt = 1'b0; sp_nxt = 1'b0; sn_nxt = 1'b0;
    unique case (cside.quad)
      2'd0: begin ac_nxt = qc; as_nxt = qs; cp_nxt = (qc != 0); sp_nxt = (qs != 0); end
      2'd1: begin ac_nxt = qs; as_nxt = qc; cn_nxt = (qs != 0); sp_nxt = (qc != 0); end
      2'd2: begin ac_nxt = qc; as_nxt = qs; cn_nxt = (qc != 0); sn_nxt = (qs != 0); end
      default: begin
        ac_nxt = qs; as_nxt = qc; cp_nxt = (qs != 0); sn_nxt = (qc != 0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!hold1) begin
      v1_r <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold1) begin
      ac1_r <= ac_nxt; as1_r <= as_nxt;
      cp1_r <= cp_nxt; cn1_r <= cn_nxt; sp1_r <= sp_nxt; sn1_r <= sn_nxt;
      w1_r  <= cside.w; h1_r <= cside.h;
    end
  end

  // ---------------- stage 2: region products
  logic          v2_r, cp2_r, cn2_r, sp2_r, sn2_r;
  logic [PW-1:0] a2_r, b2_r;
  logic [UW-1:0] ac2_r, as2_r;
  logic [CB-1:0] w2_r, h2_r;

  assign hold2 = v2_r && hold3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (!hold2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold2) begin
      a2_r  <= PW'(as1_r) * PW'(w1_r);
      b2_r  <= PW'(ac1_r) * PW'(h1_r);
      ac2_r <= ac1_r; as2_r <= as1_r;
      cp2_r <= cp1_r; cn2_r <= cn1_r; sp2_r <= sp1_r; sn2_r <= sn1_r;
      w2_r  <= w1_r; h2_r <= h1_r;
    end
  end

  // ---------------- stage 3: pick the edge
  logic                v3_r;
  logic [CB-1:0]       other3_r;
  logic [UW-1:0]       num3_r, den3_r;
  rppa_pkg::div_side_t side3_r;
  logic                vert, right, top;
  logic [CB-1:0]       other_nxt;
  logic [UW-1:0]       num_nxt, den_nxt;
  rppa_pkg::div_side_t side_nxt;

  assign hold3 = v3_r && hold4;

  always_comb begin
    priority if (a2_r > b2_r) vert = 1'b0;
    else if (a2_r < b2_r)     vert = 1'b1;
    else                      vert = !((sp2_r && cn2_r) || (sn2_r && cp2_r));
    right    = cp2_r || (ac2_r == '0 && sp2_r);
    top      = sp2_r;
    side_nxt = '0;
    side_nxt.vert = vert;
    if (vert) begin
      side_nxt.hit    = right ? rppa_pkg::HIT_RIGHT : rppa_pkg::HIT_LEFT;
      side_nxt.fix    = right ? (OW'(w2_r) << FB) : '0;
      side_nxt.size   = h2_r;
      side_nxt.toward = sp2_r;
      other_nxt       = w2_r;
      num_nxt         = as2_r;
      den_nxt         = ac2_r;
    end else begin
      side_nxt.hit    = top ? rppa_pkg::HIT_TOP : rppa_pkg::HIT_BOTTOM;
      side_nxt.fix    = top ? '0 : (OW'(h2_r) << FB);
      side_nxt.size   = w2_r;
      side_nxt.toward = cn2_r;
      other_nxt       = h2_r;
      num_nxt         = ac2_r;
      den_nxt         = as2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (!hold3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold3) begin
      other3_r <= other_nxt; num3_r <= num_nxt; den3_r <= den_nxt;
      side3_r  <= side_nxt;
    end
  end

  // ---------------- stage 4: dividend product
  logic                v4_r;
  logic [PW-1:0]       prod4_r;
  logic [UW-1:0]       den4_r;
  rppa_pkg::div_side_t side4_r;

  assign hold4 = v4_r && hold5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (!hold4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold4) begin
      prod4_r <= PW'(other3_r) * PW'(num3_r);
      den4_r  <= den3_r;
      side4_r <= side3_r;
    end
  end

  // ---------------- stage 5: divider setup, saturate large quotients
  logic                v5_r;
  logic [UW-1:0]       rem5_r, den5_r;
  logic [QW-1:0]       low5_r;
  rppa_pkg::div_side_t side5_r, side5_nxt;
  logic [NW-1:0]       nfull;
  logic                div_in_stall;

  assign hold5 = v5_r && div_in_stall;
  assign nfull = NW'(prod4_r) << FB;

  always_comb begin
    side5_nxt          = side4_r;
    side5_nxt.den_zero = (den4_r == '0);
    side5_nxt.sat      = ({(UW+QW+1)'(nfull)} >= ((UW+QW+1)'(den4_r) << QW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (!hold5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold5) begin
      rem5_r  <= UW'(nfull >> QW);
      low5_r  <= nfull[QW-1:0];
      den5_r  <= den4_r;
      side5_r <= side5_nxt;
    end
  end

  // ---------------- divider
  logic                dv;
  logic [QW-1:0]       dquo;
  rppa_pkg::div_side_t dside;

  rppa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_stall  (div_in_stall),
    .in_rem    (rem5_r),
    .in_low    (low5_r),
    .in_den    (den5_r),
    .in_side   (side5_r),
    .out_valid (dv),
    .out_stall (hold6),
    .out_quo   (dquo),
    .out_side  (dside)
  );

  // ---------------- stage 6: place the free coordinate, output register
  logic                out_valid_r;
  rppa_pkg::out_word_t out_word_r, word_nxt;
  logic [QW-1:0]       off, centre, full, v;
  logic [QW:0]         sum;
  logic [OW-1:0]       free;

  assign hold6 = out_valid_r && out_stall;

  always_comb begin
    priority if (dside.den_zero) off = '0;
    else if (dside.sat)          off = '1;
    else                         off = dquo;
    centre = QW'(dside.size) << FB;
    full   = QW'(dside.size) << (FB + 1);
    sum    = (QW+1)'(centre) + (QW+1)'(off);
    if (dside.toward) begin
      v = (off >= centre) ? '0 : QW'(centre - off);
    end else begin
      v = (sum > (QW+1)'(full)) ? full : QW'(sum);
    end
    free = OW'(((QW+1)'(v) + 1'b1) >> 1);
    word_nxt.edge_hit = dside.hit;
    word_nxt.edge_x   = dside.vert ? dside.fix : free;
    word_nxt.edge_y   = dside.vert ? free : dside.fix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold6) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold6) begin
      out_word_r <= word_nxt;
    end
  end

  assign in_stall  = hold0;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // top and bottom hits sit on y = 0 or y = height, so top must give zero y
  a_top_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.edge_hit == rppa_pkg::HIT_TOP |-> out_word.edge_y == '0)
    else $error("top hit with nonzero y");

  a_left_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.edge_hit == rppa_pkg::HIT_LEFT |-> out_word.edge_x == '0)
    else $error("left hit with nonzero x");

  // input back-pressure only comes from a full input register
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r)
    else $error("input stalled while input register empty");

  // a held output stage keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold6 |=> out_valid_r && $stable(out_word_r))
    else $error("output register changed while held");

endmodule
